[rtl/core/sshdf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SSH packet deframer package
// Result codes, character constants, framing limits and the result record
// used by the deframer.
// ----------------------------------------------------------------------------
package sshdf_pkg;

    // Result kinds.
    localparam logic [1:0] K_IDENT_BYTE = 2'd0;
    localparam logic [1:0] K_IDENT_END  = 2'd1;
    localparam logic [1:0] K_PAYLOAD    = 2'd2;
    localparam logic [1:0] K_ERROR      = 2'd3;

    // Error causes.
    localparam logic CAUSE_LENGTH  = 1'b0;
    localparam logic CAUSE_PADDING = 1'b1;

    // Characters and framing limits.
    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [7:0]  CH_LF         = 8'h0A;
    localparam logic [31:0] MIN_PACKET    = 32'd5;
    localparam logic [7:0]  MIN_PADDING   = 8'd4;
    localparam int          LEN_W         = 16;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last_of_payload;
        logic       error_cause;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/sshdf_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SSH deframer receive channel
// Valid/ready channel carrying one received byte or a new-connection request.
// ----------------------------------------------------------------------------
interface sshdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       new_connection;

    modport source (output valid, output rx_byte, output new_connection, input ready);
    modport sink   (input valid, input rx_byte, input new_connection, output ready);
endinterface
`default_nettype wire

[rtl/core/sshdf_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SSH deframer result channel
// Valid/ready channel carrying one deframer result per request.
// ----------------------------------------------------------------------------
interface sshdf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last_of_payload;
    logic       error_cause;

    modport source (output valid, output kind, output out_byte, output last_of_payload,
                    output error_cause, input ready);
    modport sink   (input valid, input kind, input out_byte, input last_of_payload,
                    input error_cause, output ready);
endinterface
`default_nettype wire

[rtl/core/ssh_packet_deframer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SSH binary packet deframer
// Byte-serial parser for the identification line and packet framing of an
// SSH connection, with a four-entry result queue.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per request on i_rx and can take a new
// request on every clock cycle while at least two result queue entries are
// free. Each byte is parsed in the cycle it is accepted: the parse state and
// the up to two results it causes are written into registers at that clock
// edge, and results leave on o_res one per request starting on the next
// cycle. A four-entry result queue sits between the two sides, so input keeps
// flowing while the consumer stalls until the queue fills; input is taken
// whenever at least two queue entries are free. The only case that produces
// two results from one byte is a lone CR in the identification line followed
// by another data byte. In ident phase, bytes up to CR LF are passed out as
// ident bytes (the first IDENT_MAX only), then an ident-end result follows.
// In packet phase the 4-byte big-endian length is checked against 5 and the
// max-length register, the padding byte against 4 and the length, the payload
// bytes are passed out with the last one marked, and the padding is dropped.
// A failed check yields one error result, after which all bytes are ignored
// until a request with new_connection set. The max-length register is written
// through i_cfg_wr_en / i_cfg_wr_data and resets to 1024; the user must write
// it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module ssh_packet_deframer_top #(
    parameter int IDENT_MAX = 63
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_wr_en,
    input  wire [sshdf_pkg::LEN_W-1:0] i_cfg_wr_data,
    sshdf_in_if.sink                  i_rx,
    sshdf_out_if.source               o_res
);
    import sshdf_pkg::*;

    // Width of the ident byte counter, enough to hold IDENT_MAX itself.
    localparam int ICW = $clog2(IDENT_MAX + 1);
    localparam logic [ICW-1:0] IDENT_LIMIT = ICW'(IDENT_MAX);

    // Parser phases.
    localparam logic [2:0] PH_IDENT   = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_PAD     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // Configuration register.
    logic [LEN_W-1:0] r_max_len;

    // Parse state.
    logic [2:0]       r_phase,      n_phase;
    logic             r_cr_pending, n_cr_pending;
    logic [ICW-1:0]   r_ident_cnt,  n_ident_cnt;
    logic [1:0]       r_len_idx,    n_len_idx;
    logic [31:0]      r_pkt_len,    n_pkt_len;
    logic [7:0]       r_pad_len,    n_pad_len;
    logic [LEN_W-1:0] r_remain,     n_remain;

    // Result queue.
    t_result          r_fifo [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_count;

    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    t_result          res0;
    t_result          res1;

    // Ident-phase helpers.
    logic             cr_emit;
    logic             byte_emit;
    logic [ICW-1:0]   cnt_after_cr;
    logic [31:0]      len_shift;
    logic [31:0]      pad_plus_one;
    logic [LEN_W-1:0] body_len;
    logic [LEN_W-1:0] remain_dec;

    // Input is taken while two queue entries are free, the worst case of one byte.
    assign i_rx.ready = (r_count <= 3'd2);
    assign accept     = i_rx.valid && i_rx.ready;

    assign o_res.valid           = (r_count != 3'd0);
    assign o_res.kind            = r_fifo[r_rd_ptr].kind;
    assign o_res.out_byte        = r_fifo[r_rd_ptr].out_byte;
    assign o_res.last_of_payload = r_fifo[r_rd_ptr].last_of_payload;
    assign o_res.error_cause     = r_fifo[r_rd_ptr].error_cause;
    assign pop                   = o_res.valid && o_res.ready;

    assign len_shift    = {r_pkt_len[23:0], i_rx.rx_byte};
    assign pad_plus_one = {24'd0, i_rx.rx_byte} + 32'd1;
    assign body_len     = r_pkt_len[LEN_W-1:0] - LEN_W'(1) - {8'd0, i_rx.rx_byte};
    assign remain_dec   = r_remain - LEN_W'(1);

    // A pending CR that is not part of CR LF is ident data and goes out first;
    // the current byte may follow it in the same step.
    assign cr_emit      = r_cr_pending && (r_ident_cnt < IDENT_LIMIT);
    assign cnt_after_cr = r_ident_cnt + ICW'(cr_emit);
    assign byte_emit    = (i_rx.rx_byte != CH_CR) && (cnt_after_cr < IDENT_LIMIT);

    always_comb begin
        n_phase      = r_phase;
        n_cr_pending = r_cr_pending;
        n_ident_cnt  = r_ident_cnt;
        n_len_idx    = r_len_idx;
        n_pkt_len    = r_pkt_len;
        n_pad_len    = r_pad_len;
        n_remain     = r_remain;
        push_n       = 2'd0;
        res0         = '0;
        res1         = '0;

        if (accept) begin
            if (i_rx.new_connection) begin
                n_phase      = PH_IDENT;
                n_cr_pending = 1'b0;
                n_ident_cnt  = '0;
                n_len_idx    = 2'd0;
                n_pkt_len    = '0;
                n_pad_len    = '0;
                n_remain     = '0;
            end else begin
                case (r_phase)
                    PH_IDENT: begin
                        if (r_cr_pending && (i_rx.rx_byte == CH_LF)) begin
                            res0.kind    = K_IDENT_END;
                            push_n       = 2'd1;
                            n_cr_pending = 1'b0;
                            n_ident_cnt  = '0;
                            n_phase      = PH_LEN;
                            n_len_idx    = 2'd0;
                            n_pkt_len    = '0;
                            n_pad_len    = '0;
                            n_remain     = '0;
                        end else begin
                            n_cr_pending = (i_rx.rx_byte == CH_CR);
                            n_ident_cnt  = cnt_after_cr + ICW'(byte_emit);
                            if (cr_emit) begin
                                res0.kind     = K_IDENT_BYTE;
                                res0.out_byte = CH_CR;
                                res1.kind     = K_IDENT_BYTE;
                                res1.out_byte = i_rx.rx_byte;
                                push_n        = byte_emit ? 2'd2 : 2'd1;
                            end else begin
                                res0.kind     = K_IDENT_BYTE;
                                res0.out_byte = i_rx.rx_byte;
                                push_n        = byte_emit ? 2'd1 : 2'd0;
                            end
                        end
                    end
                    PH_LEN: begin
                        n_pkt_len = len_shift;
                        n_len_idx = r_len_idx + 2'd1;
                        if (r_len_idx == 2'd3) begin
                            if ((len_shift < MIN_PACKET) ||
                                (len_shift > {16'd0, r_max_len})) begin
                                res0.kind        = K_ERROR;
                                res0.error_cause = CAUSE_LENGTH;
                                push_n           = 2'd1;
                                n_phase          = PH_ERROR;
                            end else begin
                                n_phase = PH_PAD;
                            end
                        end
                    end
                    PH_PAD: begin
                        n_pad_len = i_rx.rx_byte;
                        if ((i_rx.rx_byte < MIN_PADDING) || (pad_plus_one >= r_pkt_len)) begin
                            res0.kind        = K_ERROR;
                            res0.error_cause = CAUSE_PADDING;
                            push_n           = 2'd1;
                            n_phase          = PH_ERROR;
                        end else if (body_len != '0) begin
                            n_remain = body_len;
                            n_phase  = PH_PAYLOAD;
                        end else begin
                            // Empty payload: go straight to dropping the padding.
                            n_remain = {8'd0, i_rx.rx_byte};
                            n_phase  = PH_SKIP;
                        end
                    end
                    PH_PAYLOAD: begin
                        res0.kind     = K_PAYLOAD;
                        res0.out_byte = i_rx.rx_byte;
                        push_n        = 2'd1;
                        if (remain_dec == '0) begin
                            res0.last_of_payload = 1'b1;
                            n_remain             = {8'd0, r_pad_len};
                            n_phase              = PH_SKIP;
                        end else begin
                            n_remain = remain_dec;
                        end
                    end
                    PH_SKIP: begin
                        if (remain_dec == '0) begin
                            n_phase   = PH_LEN;
                            n_len_idx = 2'd0;
                            n_pkt_len = '0;
                            n_pad_len = '0;
                            n_remain  = '0;
                        end else begin
                            n_remain = remain_dec;
                        end
                    end
                    default: begin
                        // After a framing error every byte is dropped.
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_RESET;
            r_phase      <= PH_IDENT;
            r_cr_pending <= 1'b0;
            r_ident_cnt  <= '0;
            r_len_idx    <= 2'd0;
            r_pkt_len    <= '0;
            r_pad_len    <= '0;
            r_remain     <= '0;
            r_wr_ptr     <= 2'd0;
            r_rd_ptr     <= 2'd0;
            r_count      <= 3'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            r_phase      <= n_phase;
            r_cr_pending <= n_cr_pending;
            r_ident_cnt  <= n_ident_cnt;
            r_len_idx    <= n_len_idx;
            r_pkt_len    <= n_pkt_len;
            r_pad_len    <= n_pad_len;
            r_remain     <= n_remain;
            r_wr_ptr     <= r_wr_ptr + push_n;
            r_rd_ptr     <= r_rd_ptr + 2'(pop);
            r_count      <= r_count + {1'b0, push_n} - 3'(pop);
        end
    end

    // Queue storage; the second result lands in the entry after the first.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= res1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overfilled");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 3'd4) || (r_count[1:0] == 2'(r_wr_ptr - r_rd_ptr)))
        else $error("queue pointers disagree with fill count");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_rx.new_connection && (r_phase == PH_ERROR)) |=>
            (r_phase == PH_ERROR) && (r_count <= $past(r_count)))
        else $error("result produced after framing error");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx.new_connection) |=>
            (r_phase == PH_IDENT) && !r_cr_pending && (r_ident_cnt == '0))
        else $error("new connection did not restart ident phase");
`endif

endmodule
`default_nettype wire
